// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file sim_checker.sv.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The check must hold in the same cycle as the condition.
`define SIM_ASSERT_NOW(lbl, cond, chk) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (chk)) \
    else $error("sim_checker: assertion failed");

// The check must hold in the cycle after the condition.
`define SIM_ASSERT_NEXT(lbl, cond, chk) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) \
    else $error("sim_checker: assertion failed");

`endif

// ===== design/sim_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sim_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 17;
  localparam int SUM_W    = 40;
  localparam int SQ_W     = 64;
  localparam int MID_W    = 68;
  localparam int MUL_W    = 80;
  localparam int WIDE_W   = 192;
  localparam int ROOT_W   = 16;
  localparam int BIT_W    = 4;

  localparam int CORR_GAIN   = 28;
  localparam int WIDTH_GAIN  = 24;
  localparam int CORR_TOP    = 14;
  localparam int WIDTH_TOP   = 15;
  localparam int SHARE_TOP   = 13;
  localparam int SHARE_SHIFT = 28;

  localparam logic [14:0]        SHARE_ONE = 15'd16384;
  localparam logic signed [15:0] CORR_ONE  = 16'sd16384;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       last_in_window;
  } sim_in_t;

  typedef struct packed {
    logic [15:0]        width_ratio;
    logic [14:0]        mid_share;
    logic signed [15:0] correlation;
    logic [16:0]        pairs_counted;
    logic               window_overflow;
  } sim_out_t;

  typedef enum logic {
    OP_MUL    = 1'b0,
    OP_SEARCH = 1'b1
  } sim_op_t;

  typedef struct packed {
    logic             start;
    sim_op_t          op;
    logic             keep;
    logic [BIT_W-1:0] top_bit;
  } sim_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LL,
    ST_RR,
    ST_LR,
    ST_PREP,
    ST_ISSUE,
    ST_WAIT,
    ST_FIN
  } sim_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_TRY,
    U_UPD
  } sim_ustate_t;

  typedef enum logic [3:0] {
    STEP_NLL,
    STEP_VL,
    STEP_NRR,
    STEP_VR,
    STEP_NLR,
    STEP_CV,
    STEP_VPROD,
    STEP_CVSQ,
    STEP_CORR,
    STEP_WIDTH,
    STEP_SHARE
  } sim_step_t;

endpackage

`default_nettype wire

// ===== design/sim_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sim_unit import sim_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sim_req_t                 req,
  input  logic signed [WIDE_W-1:0] opnd_a,
  input  logic signed [MUL_W-1:0]  opnd_b,
  input  logic signed [WIDE_W-1:0] opnd_f,
  input  logic signed [WIDE_W-1:0] opnd_r,
  output logic                     done,
  output logic signed [WIDE_W-1:0] acc,
  output logic [ROOT_W-1:0]        root
);

  localparam int CNT_W = $clog2(MUL_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_W - 1);

  sim_ustate_t state_r, state_nxt;
  logic signed [WIDE_W-1:0] acc_r, acc_nxt;
  logic signed [WIDE_W-1:0] d_r, d_nxt;
  logic signed [WIDE_W-1:0] e_r, e_nxt;
  logic signed [WIDE_W-1:0] f_r, f_nxt;
  logic signed [WIDE_W-1:0] r_r, r_nxt;
  logic signed [MUL_W-1:0]  b_r, b_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [BIT_W-1:0]         bit_r, bit_nxt;
  logic [ROOT_W-1:0]        x_r, x_nxt;
  logic                     done_r, done_nxt;

  logic signed [WIDE_W-1:0] add_x, add_y, add_z, add_w, add_sum;
  logic                     pass;

  // The single wide adder serves both the shift-add multiply and the
  // bit-by-bit square search.
  always_comb begin
    add_x = acc_r;
    add_y = '0;
    add_z = '0;
    add_w = '0;
    unique case (state_r)
      U_MUL: begin
        if (b_r[0]) begin
          if (cnt_r == CNT_LAST) begin
            add_y = ~d_r;
            add_w = WIDE_W'(1);
          end else begin
            add_y = d_r;
          end
        end
      end
      U_TRY: begin
        add_y = d_r;
        add_z = e_r;
        add_w = f_r;
      end
      U_UPD: begin
        add_x = d_r;
        add_y = e_r <<< 1;
      end
      default: begin
      end
    endcase
  end

  assign add_sum = add_x + add_y + add_z + add_w;
  assign pass    = (add_sum <= r_r);

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    f_nxt     = f_r;
    r_nxt     = r_r;
    b_nxt     = b_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    x_nxt     = x_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      U_IDLE: begin
        if (req.start) begin
          cnt_nxt = '0;
          bit_nxt = req.top_bit;
          x_nxt   = '0;
          if (req.op == OP_MUL) begin
            if (!req.keep) begin
              acc_nxt = '0;
            end
            d_nxt     = opnd_a;
            b_nxt     = opnd_b;
            state_nxt = U_MUL;
          end else begin
            acc_nxt   = '0;
            d_nxt     = '0;
            e_nxt     = opnd_a;
            f_nxt     = opnd_f;
            r_nxt     = opnd_r;
            state_nxt = U_TRY;
          end
        end
      end
      U_MUL: begin
        acc_nxt = add_sum;
        d_nxt   = d_r <<< 1;
        b_nxt   = b_r >>> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = U_IDLE;
          done_nxt  = 1'b1;
        end
      end
      U_TRY: begin
        if (pass) begin
          acc_nxt      = add_sum;
          x_nxt[bit_r] = 1'b1;
          state_nxt    = U_UPD;
        end else begin
          d_nxt   = d_r >>> 1;
          e_nxt   = e_r >>> 2;
          f_nxt   = f_r >>> 1;
          bit_nxt = bit_r - 1'b1;
          if (bit_r == '0) begin
            state_nxt = U_IDLE;
            done_nxt  = 1'b1;
          end
        end
      end
      U_UPD: begin
        d_nxt   = add_sum >>> 1;
        e_nxt   = e_r >>> 2;
        f_nxt   = f_r >>> 1;
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          state_nxt = U_IDLE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = U_TRY;
        end
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    f_r   <= f_nxt;
    r_r   <= r_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
    bit_r <= bit_nxt;
    x_r   <= x_nxt;
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign root = x_r;

endmodule

`default_nettype wire

// ===== design/stereo_image_meter.sv =====
// Stereo image meter. Sample pairs arrive one per transaction on the input
// channel and are summed over a window that ends with the pair flagged
// last_in_window; that window then yields one result transaction with the
// width ratio, mid share, Pearson correlation, pair count and overflow flag.
// Each pair occupies the block from its accept in ST_IDLE through the ST_LL,
// ST_RR and ST_LR states on the one 24 by 24 multiplier that forms L*L,
// R*R and L*R, and no new pair is taken before it is through. At the end
// of a window the block stays busy on the shared wide adder: eight
// shift-add multiplies, each with issue, adder run and completion, then
// three bit-by-bit square searches (a try, then an update if it passes).
// A finished result sits in an output register, so the next window can be
// summed while it waits. Pairs beyond MAX_SAMPLES are dropped and flagged.
`timescale 1ns / 1ps
`default_nettype none

module stereo_image_meter import sim_pkg::*; #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sim_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sim_out_t out_data
);

  sim_state_t state_r, state_nxt;
  sim_step_t  step_r, step_nxt;

  logic signed [SAMPLE_W-1:0] l_r, l_nxt, r_r, r_nxt;
  logic                       last_r, last_nxt;
  logic                       take_r, take_nxt;

  logic [COUNT_W-1:0]       pair_count_r, pair_count_nxt;
  logic signed [SUM_W-1:0]  sum_l_r, sum_l_nxt, sum_r_r, sum_r_nxt;
  logic [SQ_W-1:0]          sum_ll_r, sum_ll_nxt, sum_rr_r, sum_rr_nxt;
  logic signed [SQ_W-1:0]   sum_lr_r, sum_lr_nxt;
  logic                     ovf_r, ovf_nxt;

  logic signed [MID_W-1:0]  m4_r, m4_nxt, s4_r, s4_nxt;
  logic signed [MUL_W-1:0]  vl_r, vl_nxt, vr_r, vr_nxt, cv_r, cv_nxt;
  logic signed [WIDE_W-1:0] vprod_r, vprod_nxt, cvsq_r, cvsq_nxt;
  logic [ROOT_W-1:0]        corr_k_r, corr_k_nxt;
  logic [ROOT_W-1:0]        width_k_r, width_k_nxt;
  logic [ROOT_W-1:0]        share_k_r, share_k_nxt;

  logic     out_valid_r, out_valid_nxt;
  sim_out_t out_data_r, out_data_nxt;

  logic signed [SAMPLE_W-1:0]   l_ext, r_ext, mul_a, mul_b;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic signed [MID_W-1:0]      ll_w, rr_w, lr2_w;
  logic                         accept;

  sim_req_t                 req;
  logic signed [WIDE_W-1:0] opnd_a, opnd_f, opnd_r;
  logic signed [MUL_W-1:0]  opnd_b;
  logic                     u_done;
  logic signed [WIDE_W-1:0] u_acc;
  logic [ROOT_W-1:0]        u_root;

  assign l_ext = SAMPLE_W'($signed(in_data.left_sample[SAMPLE_BITS-1:0]));
  assign r_ext = SAMPLE_W'($signed(in_data.right_sample[SAMPLE_BITS-1:0]));

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mul_a = l_r;
    mul_b = l_r;
    unique case (state_r)
      ST_RR: begin
        mul_a = r_r;
        mul_b = r_r;
      end
      ST_LR: begin
        mul_b = r_r;
      end
      default: begin
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign ll_w  = $signed(MID_W'(sum_ll_r));
  assign rr_w  = $signed(MID_W'(sum_rr_r));
  assign lr2_w = MID_W'(sum_lr_r) <<< 1;

  // Operands for the shared unit, one set per step of the end-of-window run.
  always_comb begin
    req.start   = (state_r == ST_ISSUE);
    req.op      = OP_MUL;
    req.keep    = 1'b0;
    req.top_bit = '0;
    opnd_a      = '0;
    opnd_b      = '0;
    opnd_f      = '0;
    opnd_r      = '0;
    unique case (step_r)
      STEP_NLL: begin
        opnd_a = WIDE_W'(sum_ll_r);
        opnd_b = MUL_W'(pair_count_r);
      end
      STEP_VL: begin
        req.keep = 1'b1;
        opnd_a   = WIDE_W'(sum_l_r);
        opnd_b   = -MUL_W'(sum_l_r);
      end
      STEP_NRR: begin
        opnd_a = WIDE_W'(sum_rr_r);
        opnd_b = MUL_W'(pair_count_r);
      end
      STEP_VR: begin
        req.keep = 1'b1;
        opnd_a   = WIDE_W'(sum_r_r);
        opnd_b   = -MUL_W'(sum_r_r);
      end
      STEP_NLR: begin
        opnd_a = WIDE_W'(sum_lr_r);
        opnd_b = MUL_W'(pair_count_r);
      end
      STEP_CV: begin
        req.keep = 1'b1;
        opnd_a   = WIDE_W'(sum_l_r);
        opnd_b   = -MUL_W'(sum_r_r);
      end
      STEP_VPROD: begin
        opnd_a = WIDE_W'(vl_r);
        opnd_b = vr_r;
      end
      STEP_CVSQ: begin
        opnd_a = WIDE_W'(cv_r) <<< CORR_GAIN;
        opnd_b = cv_r;
      end
      STEP_CORR: begin
        req.op      = OP_SEARCH;
        req.top_bit = BIT_W'(CORR_TOP);
        opnd_a      = vprod_r <<< (2 * CORR_TOP);
        opnd_r      = cvsq_r;
      end
      STEP_WIDTH: begin
        req.op      = OP_SEARCH;
        req.top_bit = BIT_W'(WIDTH_TOP);
        opnd_a      = WIDE_W'(m4_r) <<< (2 * WIDTH_TOP);
        opnd_r      = WIDE_W'(s4_r) <<< WIDTH_GAIN;
      end
      STEP_SHARE: begin
        req.op      = OP_SEARCH;
        req.top_bit = BIT_W'(SHARE_TOP);
        opnd_a      = WIDE_W'(s4_r - m4_r) <<< (2 * SHARE_TOP);
        opnd_f      = WIDE_W'(m4_r) <<< SHARE_SHIFT;
        opnd_r      = WIDE_W'(m4_r) <<< SHARE_SHIFT;
      end
      default: begin
      end
    endcase
  end

  sim_unit u_sim_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .opnd_f (opnd_f),
    .opnd_r (opnd_r),
    .done   (u_done),
    .acc    (u_acc),
    .root   (u_root)
  );

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    l_nxt          = l_r;
    r_nxt          = r_r;
    last_nxt       = last_r;
    take_nxt       = take_r;
    pair_count_nxt = pair_count_r;
    sum_l_nxt      = sum_l_r;
    sum_r_nxt      = sum_r_r;
    sum_ll_nxt     = sum_ll_r;
    sum_rr_nxt     = sum_rr_r;
    sum_lr_nxt     = sum_lr_r;
    ovf_nxt        = ovf_r;
    m4_nxt         = m4_r;
    s4_nxt         = s4_r;
    vl_nxt         = vl_r;
    vr_nxt         = vr_r;
    cv_nxt         = cv_r;
    vprod_nxt      = vprod_r;
    cvsq_nxt       = cvsq_r;
    corr_k_nxt     = corr_k_r;
    width_k_nxt    = width_k_r;
    share_k_nxt    = share_k_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          l_nxt     = l_ext;
          r_nxt     = r_ext;
          last_nxt  = in_data.last_in_window;
          take_nxt  = (pair_count_r < COUNT_W'(MAX_SAMPLES));
          state_nxt = ST_LL;
          if (pair_count_r < COUNT_W'(MAX_SAMPLES)) begin
            pair_count_nxt = pair_count_r + 1'b1;
            sum_l_nxt      = sum_l_r + SUM_W'(l_ext);
            sum_r_nxt      = sum_r_r + SUM_W'(r_ext);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_LL: begin
        if (take_r) begin
          sum_ll_nxt = sum_ll_r + SQ_W'($unsigned(prod));
        end
        state_nxt = ST_RR;
      end
      ST_RR: begin
        if (take_r) begin
          sum_rr_nxt = sum_rr_r + SQ_W'($unsigned(prod));
        end
        state_nxt = ST_LR;
      end
      ST_LR: begin
        if (take_r) begin
          sum_lr_nxt = sum_lr_r + SQ_W'(prod);
        end
        state_nxt = last_r ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        m4_nxt    = ll_w + rr_w + lr2_w;
        s4_nxt    = ll_w + rr_w - lr2_w;
        step_nxt  = STEP_NLL;
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (u_done) begin
          unique case (step_r)
            STEP_VL:    vl_nxt      = u_acc[MUL_W-1:0];
            STEP_VR:    vr_nxt      = u_acc[MUL_W-1:0];
            STEP_CV:    cv_nxt      = u_acc[MUL_W-1:0];
            STEP_VPROD: vprod_nxt   = u_acc;
            STEP_CVSQ:  cvsq_nxt    = u_acc;
            STEP_CORR:  corr_k_nxt  = u_root;
            STEP_WIDTH: width_k_nxt = u_root;
            STEP_SHARE: share_k_nxt = u_root;
            default: begin
            end
          endcase
          if (step_r == STEP_SHARE) begin
            state_nxt = ST_FIN;
          end else begin
            step_nxt  = sim_step_t'(step_r + 1'b1);
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.width_ratio = (s4_r == '0) ? '0 : width_k_r;
          if (s4_r == '0) begin
            out_data_nxt.mid_share = (m4_r == '0) ? '0 : SHARE_ONE;
          end else begin
            out_data_nxt.mid_share = share_k_r[14:0];
          end
          if (vl_r == '0 || vr_r == '0) begin
            out_data_nxt.correlation = CORR_ONE;
          end else if (cv_r < 0) begin
            out_data_nxt.correlation = -$signed(corr_k_r);
          end else begin
            out_data_nxt.correlation = $signed(corr_k_r);
          end
          out_data_nxt.pairs_counted   = pair_count_r;
          out_data_nxt.window_overflow = ovf_r;
          pair_count_nxt = '0;
          sum_l_nxt      = '0;
          sum_r_nxt      = '0;
          sum_ll_nxt     = '0;
          sum_rr_nxt     = '0;
          sum_lr_nxt     = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= STEP_NLL;
      pair_count_r <= '0;
      sum_l_r      <= '0;
      sum_r_r      <= '0;
      sum_ll_r     <= '0;
      sum_rr_r     <= '0;
      sum_lr_r     <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      pair_count_r <= pair_count_nxt;
      sum_l_r      <= sum_l_nxt;
      sum_r_r      <= sum_r_nxt;
      sum_ll_r     <= sum_ll_nxt;
      sum_rr_r     <= sum_rr_nxt;
      sum_lr_r     <= sum_lr_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    last_r     <= last_nxt;
    take_r     <= take_nxt;
    m4_r       <= m4_nxt;
    s4_r       <= s4_nxt;
    vl_r       <= vl_nxt;
    vr_r       <= vr_nxt;
    cv_r       <= cv_nxt;
    vprod_r    <= vprod_nxt;
    cvsq_r     <= cvsq_nxt;
    corr_k_r   <= corr_k_nxt;
    width_k_r  <= width_k_nxt;
    share_k_r  <= share_k_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/sim_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sim_checker import sim_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input sim_out_t out_data
);

  `SIM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SIM_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  `SIM_ASSERT_NOW(a_share_range, out_valid, out_data.mid_share <= SHARE_ONE)
  `SIM_ASSERT_NOW(a_corr_range, out_valid, (out_data.correlation <= CORR_ONE) && (out_data.correlation >= -CORR_ONE))
  `SIM_ASSERT_NOW(a_count_nonzero, out_valid, out_data.pairs_counted != '0)

endmodule

bind stereo_image_meter sim_checker u_sim_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sim_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int unsigned WINDOW_CAP = 65536;
  localparam longint unsigned CYCLE_LIMIT = 10000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  sim_in_t in_data;
  logic out_valid;
  logic out_stall;
  sim_out_t out_data;

  stereo_image_meter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  sim_out_t pending_meters[$];
  int unsigned failures;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_off_left;
  longint unsigned cycle_count;

  int unsigned win_pairs;
  wide_t win_sum_l, win_sum_r, win_sum_ll, win_sum_rr, win_sum_lr;
  logic win_dropped;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned largest_root(int unsigned top, wide_t lhs, wide_t rhs);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = top;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (wide_t'(mid) * wide_t'(mid) * lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic int unsigned largest_share(wide_t mid4, wide_t side4);
    int unsigned lo;
    int unsigned hi;
    int unsigned s;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      s = lo + (hi - lo + 1) / 2;
      if (wide_t'(s) * wide_t'(s) * side4 <=
          wide_t'(16384 - s) * wide_t'(16384 - s) * mid4) lo = s;
      else hi = s - 1;
    end
    return lo;
  endfunction

  task automatic clear_window_sums();
    win_pairs = 0;
    win_sum_l = '0;
    win_sum_r = '0;
    win_sum_ll = '0;
    win_sum_rr = '0;
    win_sum_lr = '0;
    win_dropped = 1'b0;
  endtask

  task automatic predict_meters(sim_in_t pair);
    wide_t l, r, mid4, side4, var_l, var_r, cov, n;
    sim_out_t res;
    int unsigned k;
    logic neg;
    l = wide_t'(pair.left_sample);
    r = wide_t'(pair.right_sample);
    if (win_pairs < WINDOW_CAP) begin
      win_pairs++;
      win_sum_l += l;
      win_sum_r += r;
      win_sum_ll += l * l;
      win_sum_rr += r * r;
      win_sum_lr += l * r;
    end else begin
      win_dropped = 1'b1;
    end
    if (!pair.last_in_window) return;
    mid4 = win_sum_ll + win_sum_rr + 2 * win_sum_lr;
    side4 = win_sum_ll + win_sum_rr - 2 * win_sum_lr;
    res.width_ratio = (side4 == 0) ? 16'd0
        : 16'(largest_root(65535, mid4, side4 <<< WIDTH_GAIN));
    res.mid_share = (mid4 == 0 && side4 == 0) ? 15'd0 : 15'(largest_share(mid4, side4));
    n = wide_t'(win_pairs);
    var_l = n * win_sum_ll - win_sum_l * win_sum_l;
    var_r = n * win_sum_rr - win_sum_r * win_sum_r;
    cov = n * win_sum_lr - win_sum_l * win_sum_r;
    if (var_l <= 0 || var_r <= 0) begin
      res.correlation = CORR_ONE;
    end else begin
      neg = cov < 0;
      if (neg) cov = -cov;
      k = largest_root(16384, var_l * var_r, (cov * cov) <<< CORR_GAIN);
      res.correlation = neg ? -16'(k) : 16'(k);
    end
    res.pairs_counted = 17'(win_pairs);
    res.window_overflow = win_dropped;
    pending_meters.push_back(res);
    clear_window_sums();
  endtask

  task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.left_sample = l;
    in_data.right_sample = r;
    in_data.last_in_window = last;
    do @(posedge clk); while (in_stall);
    predict_meters(in_data);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_meters.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_stall = 1'b1;
      hold_off_left--;
    end else begin
      out_stall = $urandom_range(0, 99) < stall_pct;
    end
  end

  always @(posedge clk) begin
    sim_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_meters.size() == 0) begin
        $error("unexpected result transaction");
        failures++;
      end else begin
        exp_res = pending_meters.pop_front();
        if (out_data.width_ratio !== exp_res.width_ratio) begin
          $error("width_ratio expected %0d got %0d", exp_res.width_ratio,
                 out_data.width_ratio);
          failures++;
        end
        if (out_data.mid_share !== exp_res.mid_share) begin
          $error("mid_share expected %0d got %0d", exp_res.mid_share, out_data.mid_share);
          failures++;
        end
        if (out_data.correlation !== exp_res.correlation) begin
          $error("correlation expected %0d got %0d", exp_res.correlation,
                 out_data.correlation);
          failures++;
        end
        if (out_data.pairs_counted !== exp_res.pairs_counted) begin
          $error("pairs_counted expected %0d got %0d", exp_res.pairs_counted,
                 out_data.pairs_counted);
          failures++;
        end
        if (out_data.window_overflow !== exp_res.window_overflow) begin
          $error("window_overflow expected %0d got %0d", exp_res.window_overflow,
                 out_data.window_overflow);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed_cases();
    send_pair(24'sd1000, -24'sd77, 1'b1);
    send_pair(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    send_pair(-24'sh800000, -24'sh800000, 1'b1);
    send_pair(24'sd0, 24'sd0, 1'b0);
    send_pair(24'sd0, 24'sd0, 1'b1);
    send_pair(24'sh7FFFFF, -24'sh7FFFFF, 1'b0);
    send_pair(-24'sd5000, 24'sd5000, 1'b1);
    send_pair(24'sh7FFFFF, -24'sh800000, 1'b0);
    send_pair(-24'sh800000, 24'sh7FFFFF, 1'b1);
    send_pair(24'sd300, 24'sd200, 1'b0);
    send_pair(24'sd300, 24'sd900, 1'b0);
    send_pair(-24'sd100, 24'sd50, 1'b1);
    send_pair(24'sd12345, 24'sd12345, 1'b0);
    send_pair(24'sd12345, 24'sd12345, 1'b1);
    send_pair(24'sd7, 24'sd1, 1'b0);
    send_pair(24'sd8, 24'sd1, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_windows(int unsigned pairs_to_send);
    int unsigned sent;
    int unsigned len;
    int unsigned style;
    logic signed [23:0] l, r;
    sent = 0;
    while (sent < pairs_to_send) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      style = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        l = 24'($urandom);
        case (style)
          0: r = 24'($urandom);
          1: r = l + 24'($signed($urandom_range(0, 2000)) - 1000);
          2: r = -l + 24'($signed($urandom_range(0, 2000)) - 1000);
          default: begin
            l = 24'($signed($urandom_range(0, 4000)) - 2000);
            r = 24'($signed($urandom_range(0, 4000)) - 2000);
          end
        endcase
        send_pair(l, r, i == len - 1);
      end
      sent += len;
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    hold_off_left = 5000;
    for (int w = 0; w < 4; w++)
      for (int i = 0; i < 5; i++)
        send_pair(24'($urandom), 24'($urandom), i == 4);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    failures = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_left = 0;
    cycle_count = 0;
    clear_window_sums();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_random_windows(450);
    send_idle_pct = 51;
    test_random_windows(450);
    send_idle_pct = 0;
    stall_pct = 51;
    test_random_windows(450);
    send_idle_pct = 14;
    stall_pct = 14;
    test_random_windows(450);
    send_idle_pct = 0;
    stall_pct = 0;
    test_output_backpressure();

    repeat (1000) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
